>>> hdl/assert_macros.svh
// Assertion macros for the fasthash64 stream modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define FH_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define FH_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define FH_ASSERT(lbl, clk, rstn, prop, msg)

`define FH_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> hdl/fh64_pkg.sv
// Types, constants and helper functions for the fasthash64 word stream.
package fh64_pkg;

    localparam int DataW     = 64;
    localparam int LenW      = 32;
    localparam int KindW     = 2;
    localparam int CfgIndexW = 1;
    localparam int HalfW     = DataW / 2;

    localparam logic [DataW-1:0] HashMult = 64'h8803_55f2_1e6d_1965;
    localparam logic [DataW-1:0] MixMult  = 64'h2127_599b_f432_5c37;
    localparam int MixShiftA = 23;
    localparam int MixShiftB = 47;

    typedef enum logic [KindW-1:0] {
        REQ_NOP0  = 2'd0,
        REQ_NOP1  = 2'd1,
        REQ_BODY  = 2'd2,
        REQ_FINAL = 2'd3
    } req_type_t;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_HASH_SEED      = 1'b0,
        CFG_MESSAGE_LENGTH = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        A_LENGTH    = 2'd0,
        A_WORD      = 2'd1,
        A_ACC_MIXED = 2'd2,
        A_ACC_PRE   = 2'd3
    } a_sel_t;

    typedef enum logic {
        B_HASH = 1'b0,
        B_MIX  = 1'b1
    } b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD  = 2'd0,
        ACC_SEED  = 2'd1,
        ACC_PROD  = 2'd2,
        ACC_CLEAR = 2'd3
    } acc_op_t;

    typedef struct packed {
        logic    in_ready;
        logic    item_load;
        logic    mul_start;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t acc_op;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic mul_done;
        logic out_full;
        logic kind_final;
        logic tail_zero;
    } status_t;

    function automatic logic [DataW-1:0] pre_mix(input logic [DataW-1:0] x);
        return x ^ (x >> MixShiftA);
    endfunction

    function automatic logic [DataW-1:0] post_mix(input logic [DataW-1:0] x);
        return x ^ (x >> MixShiftB);
    endfunction

    function automatic logic [DataW-1:0] tail_mask(input logic [2:0] tail);
        return ~({DataW{1'b1}} << {tail, 3'b000});
    endfunction

endpackage

>>> hdl/fh64_ctrl.sv
// Sequencing state machine for the fasthash64 word stream.
`include "assert_macros.svh"

module fh64_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic [fh64_pkg::KindW-1:0]    s_tuser,
    input  fh64_pkg::status_t             status,
    output fh64_pkg::cmd_t                cmd
);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_DISPATCH  = 8'b0000_0010,
        ST_SEED      = 8'b0000_0100,
        ST_ABS_MIX   = 8'b0000_1000,
        ST_ABS_ACC   = 8'b0001_0000,
        ST_FIN_START = 8'b0010_0000,
        ST_FIN_MIX   = 8'b0100_0000,
        ST_FIN_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   started_reg, started_next;
    logic   active_kind;

    assign active_kind = (s_tuser == fh64_pkg::REQ_BODY) || (s_tuser == fh64_pkg::REQ_FINAL);

    always_comb begin
        state_next   = state_reg;
        started_next = started_reg;
        cmd          = '0;
        cmd.a_sel    = fh64_pkg::A_WORD;
        cmd.b_sel    = fh64_pkg::B_MIX;
        cmd.acc_op   = fh64_pkg::ACC_HOLD;
        case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_tvalid) begin
                    cmd.item_load = 1'b1;
                    if (active_kind) begin
                        state_next = ST_DISPATCH;
                    end
                end
            end
            ST_DISPATCH: begin
                cmd.mul_start = 1'b1;
                if (!started_reg) begin
                    cmd.a_sel  = fh64_pkg::A_LENGTH;
                    cmd.b_sel  = fh64_pkg::B_HASH;
                    state_next = ST_SEED;
                end else if (!status.kind_final || !status.tail_zero) begin
                    cmd.a_sel  = fh64_pkg::A_WORD;
                    cmd.b_sel  = fh64_pkg::B_MIX;
                    state_next = ST_ABS_MIX;
                end else begin
                    cmd.a_sel  = fh64_pkg::A_ACC_PRE;
                    cmd.b_sel  = fh64_pkg::B_MIX;
                    state_next = ST_FIN_MIX;
                end
            end
            ST_SEED: begin
                if (status.mul_done) begin
                    cmd.acc_op   = fh64_pkg::ACC_SEED;
                    started_next = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_ABS_MIX: begin
                if (status.mul_done) begin
                    cmd.mul_start = 1'b1;
                    cmd.a_sel     = fh64_pkg::A_ACC_MIXED;
                    cmd.b_sel     = fh64_pkg::B_HASH;
                    state_next    = ST_ABS_ACC;
                end
            end
            ST_ABS_ACC: begin
                if (status.mul_done) begin
                    cmd.acc_op = fh64_pkg::ACC_PROD;
                    state_next = status.kind_final ? ST_FIN_START : ST_IDLE;
                end
            end
            ST_FIN_START: begin
                cmd.mul_start = 1'b1;
                cmd.a_sel     = fh64_pkg::A_ACC_PRE;
                cmd.b_sel     = fh64_pkg::B_MIX;
                state_next    = ST_FIN_MIX;
            end
            ST_FIN_MIX: begin
                if (status.mul_done) begin
                    state_next = ST_FIN_OUT;
                end
            end
            ST_FIN_OUT: begin
                if (!status.out_full) begin
                    cmd.out_load = 1'b1;
                    cmd.acc_op   = fh64_pkg::ACC_CLEAR;
                    started_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
        end
    end

    `FH_ASSERT_IMPL(a_start_idle_mul, aclk, aresetn, cmd.mul_start, !status.mul_busy, "multiply started while busy")
    `FH_ASSERT_IMPL(a_load_free_out, aclk, aresetn, cmd.out_load, !status.out_full, "result overwrites pending transfer")
    `FH_ASSERT_IMPL(a_end_on_output, aclk, aresetn, $fell(started_reg) && $past(aresetn), $past(cmd.out_load), "message closed without result")

endmodule

>>> hdl/fh64_datapath.sv
// Datapath: config registers, accumulator, shared 32x32 multiplier and output register.
module fh64_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fh64_pkg::CfgIndexW-1:0]    cfg_index,
    input  logic [fh64_pkg::DataW-1:0]        cfg_wr_data,
    input  logic [fh64_pkg::DataW-1:0]        s_tdata,
    input  logic [fh64_pkg::KindW-1:0]        s_tuser,
    input  logic                              m_tready,
    input  fh64_pkg::cmd_t                    cmd,
    output fh64_pkg::status_t                 status,
    output logic                              m_tvalid,
    output logic [fh64_pkg::DataW-1:0]        m_tdata
);

    localparam int DW = fh64_pkg::DataW;
    localparam int HW = fh64_pkg::HalfW;

    logic [DW-1:0]                 seed_reg;
    logic [fh64_pkg::LenW-1:0]     length_reg;
    logic [DW-1:0]                 word_reg;
    fh64_pkg::req_type_t           kind_reg;
    logic [DW-1:0]                 acc_reg, acc_next;
    logic [DW-1:0]                 opa_reg, opa_next;
    logic [DW-1:0]                 opb_reg, opb_next;
    logic [DW-1:0]                 mprod_reg;
    logic [DW-1:0]                 prod_reg;
    logic [1:0]                    phase_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic                          out_valid_reg;
    logic [DW-1:0]                 hash_reg;
    logic [DW-1:0]                 word_in;
    logic [DW-1:0]                 seed_init;
    logic [HW-1:0]                 mul_a, mul_b;
    logic [HW-1:0]                 prod_hi_sum;

    assign word_in = (kind_reg == fh64_pkg::REQ_FINAL)
                   ? (word_reg & fh64_pkg::tail_mask(length_reg[2:0])) : word_reg;
    assign seed_init   = seed_reg ^ prod_reg;
    assign prod_hi_sum = prod_reg[DW-1:HW] + mprod_reg[HW-1:0];

    always_comb begin
        case (cmd.a_sel)
            fh64_pkg::A_LENGTH:    opa_next = {{(DW - fh64_pkg::LenW){1'b0}}, length_reg};
            fh64_pkg::A_WORD:      opa_next = fh64_pkg::pre_mix(word_in);
            fh64_pkg::A_ACC_MIXED: opa_next = acc_reg ^ fh64_pkg::post_mix(prod_reg);
            fh64_pkg::A_ACC_PRE:   opa_next = fh64_pkg::pre_mix(acc_reg);
            default:               opa_next = acc_reg;
        endcase
        case (cmd.b_sel)
            fh64_pkg::B_HASH: opb_next = fh64_pkg::HashMult;
            fh64_pkg::B_MIX:  opb_next = fh64_pkg::MixMult;
            default:          opb_next = fh64_pkg::HashMult;
        endcase
        case (cmd.acc_op)
            fh64_pkg::ACC_HOLD:  acc_next = acc_reg;
            fh64_pkg::ACC_SEED:  acc_next = (seed_init == '0) ? {{(DW-1){1'b0}}, 1'b1} : seed_init;
            fh64_pkg::ACC_PROD:  acc_next = prod_reg;
            fh64_pkg::ACC_CLEAR: acc_next = '0;
            default:             acc_next = acc_reg;
        endcase
    end

    // low x low, low x high, high x low; cross terms only reach the upper half
    assign mul_a = (phase_reg == 2'd2) ? opa_reg[DW-1:HW] : opa_reg[HW-1:0];
    assign mul_b = (phase_reg == 2'd1) ? opb_reg[DW-1:HW] : opb_reg[HW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= '0;
            length_reg    <= '0;
            acc_reg       <= '0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (fh64_pkg::cfg_index_t'(cfg_index))
                    fh64_pkg::CFG_HASH_SEED:      seed_reg   <= cfg_wr_data;
                    fh64_pkg::CFG_MESSAGE_LENGTH: length_reg <= cfg_wr_data[fh64_pkg::LenW-1:0];
                    default: ;
                endcase
            end
            acc_reg  <= acc_next;
            done_reg <= busy_reg && (phase_reg == 2'd3);
            if (cmd.mul_start) begin
                busy_reg  <= 1'b1;
                phase_reg <= 2'd0;
            end else if (busy_reg) begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            word_reg <= s_tdata;
            kind_reg <= fh64_pkg::req_type_t'(s_tuser);
        end
        if (cmd.mul_start) begin
            opa_reg <= opa_next;
            opb_reg <= opb_next;
        end
        mprod_reg <= mul_a * mul_b;
        if (busy_reg) begin
            case (phase_reg)
                2'd1:    prod_reg <= mprod_reg;
                2'd2:    prod_reg[DW-1:HW] <= prod_hi_sum;
                2'd3:    prod_reg[DW-1:HW] <= prod_hi_sum;
                default: ;
            endcase
        end
        if (cmd.out_load) begin
            hash_reg <= fh64_pkg::post_mix(prod_reg);
        end
    end

    assign status.mul_busy   = busy_reg;
    assign status.mul_done   = done_reg;
    assign status.out_full   = out_valid_reg;
    assign status.kind_final = (kind_reg == fh64_pkg::REQ_FINAL);
    assign status.tail_zero  = (length_reg[2:0] == 3'd0);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = hash_reg;

endmodule

>>> hdl/fasthash64_word_stream.sv
// Top level of the fasthash64 word stream hasher.
//
// Input stream: s_tdata carries one 64-bit message word (first byte lowest),
// s_tuser the word kind: body word, final tail word, or two no-op codes.
// A message is any number of body words closed by one final word; the final
// word keeps only its low (message_length mod 8) bytes. One hash leaves on
// the m_ stream for each final word. hash_seed and message_length are written
// through cfg_wr_en / cfg_index / cfg_wr_data; the user must write them only
// while no message is in flight, which the block itself does not enforce.
// s_tready is high only while idle, so a new word is taken only once the
// previous one is fully processed. Every 64-bit product runs through one
// 32x32 multiplier in four passes, after which the multiplier raises its
// done strobe. The hash appears on m_tvalid in the same cycle in which the
// next word can be taken. If the receiver stalls, the hash holds in the
// output register; the next message proceeds until its own hash is due,
// then waits for the transfer.
// Reset (aresetn low, synchronous) clears both config registers, the
// accumulator, the message-open flag and the output valid.
module fasthash64_word_stream (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fh64_pkg::CfgIndexW-1:0]    cfg_index,
    input  logic [fh64_pkg::DataW-1:0]        cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fh64_pkg::DataW-1:0]        s_tdata,   // [63:0] data_word
    input  logic [fh64_pkg::KindW-1:0]        s_tuser,   // [1:0] req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fh64_pkg::DataW-1:0]        m_tdata    // [63:0] hash_value
);

    fh64_pkg::cmd_t    cmd;
    fh64_pkg::status_t status;

    fh64_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    fh64_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

    assign s_tready = cmd.in_ready;

endmodule
